// ===== src/rpsf_pkg.sv =====
// Shared types and constants for the rectangle point SPI framer.
package rpsf_pkg;

    localparam int COORD_BITS  = 8;
    localparam int WORD_BITS   = 16;
    localparam int FRAME_LEN   = 13;
    localparam int IDX_W       = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CMD_COL = 8'h2A;
    localparam logic [7:0] CMD_ROW = 8'h2B;
    localparam logic [7:0] CMD_MEM = 8'h2C;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic REG_FORE_COLOR  = 1'b0;
    localparam logic REG_ORIENTATION = 1'b1;

    localparam logic [IDX_W-1:0] POS_CMD_COL = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_XS_HI   = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_XS_LO   = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_XE_HI   = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_XE_LO   = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_CMD_ROW = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_YS_HI   = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_YS_LO   = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_YE_HI   = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_YE_LO   = IDX_W'(9);
    localparam logic [IDX_W-1:0] POS_CMD_MEM = IDX_W'(10);
    localparam logic [IDX_W-1:0] POS_COL_HI  = IDX_W'(11);
    localparam logic [IDX_W-1:0] POS_COL_LO  = IDX_W'(12);

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] corner_ax;
        logic [COORD_BITS-1:0] corner_ay;
        logic [COORD_BITS-1:0] corner_bx;
        logic [COORD_BITS-1:0] corner_by;
        logic                  fill_mode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_data;
        logic       point_last;
        logic       rect_done;
    } t_out_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] xw;
        logic [WORD_BITS-1:0] yw;
        logic                 last;
    } t_point;

endpackage

// ===== src/rpsf_front.sv =====
// Front end: takes load and step transfers, walks the rectangle and queues window points.
module rpsf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rpsf_pkg::t_in_item i_in,
    input  logic [1:0]       i_orientation,
    input  logic             i_q_full,
    output logic             o_full,
    output logic             o_q_push,
    output rpsf_pkg::t_point o_q_data
);
    import rpsf_pkg::*;

    logic [COORD_BITS-1:0] r_left_x, r_right_x, r_top_y, r_bottom_y, r_walk_x, r_walk_y;
    logic [COORD_BITS-1:0] n_left_x, n_right_x, n_top_y, n_bottom_y, n_walk_x, n_walk_y;
    logic r_fill, r_phase, r_pair, r_busy;
    logic n_fill, n_phase, n_pair, n_busy;
    logic accept, last;
    logic [COORD_BITS-1:0] px, py;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        n_left_x   = r_left_x;
        n_right_x  = r_right_x;
        n_top_y    = r_top_y;
        n_bottom_y = r_bottom_y;
        n_walk_x   = r_walk_x;
        n_walk_y   = r_walk_y;
        n_fill     = r_fill;
        n_phase    = r_phase;
        n_pair     = r_pair;
        n_busy     = r_busy;
        px         = r_walk_x;
        py         = r_walk_y;
        last       = 1'b0;
        o_q_push   = 1'b0;
        if (accept && i_in.kind == KIND_LOAD) begin
            n_left_x   = (i_in.corner_ax < i_in.corner_bx) ? i_in.corner_ax : i_in.corner_bx;
            n_right_x  = (i_in.corner_ax < i_in.corner_bx) ? i_in.corner_bx : i_in.corner_ax;
            n_top_y    = (i_in.corner_ay < i_in.corner_by) ? i_in.corner_ay : i_in.corner_by;
            n_bottom_y = (i_in.corner_ay < i_in.corner_by) ? i_in.corner_by : i_in.corner_ay;
            n_walk_x   = n_left_x;
            n_walk_y   = n_top_y;
            n_fill     = i_in.fill_mode;
            n_phase    = 1'b0;
            n_pair     = 1'b0;
            n_busy     = 1'b1;
        end else if (accept && r_busy) begin
            o_q_push = 1'b1;
            if (r_fill) begin
                if (r_walk_y < r_bottom_y) begin
                    n_walk_y = r_walk_y + 1'b1;
                end else begin
                    n_walk_y = r_top_y;
                    if (r_walk_x < r_right_x) begin
                        n_walk_x = r_walk_x + 1'b1;
                    end else begin
                        last = 1'b1;
                    end
                end
            end else if (!r_phase) begin
                if (!r_pair) begin
                    px     = r_left_x;
                    n_pair = 1'b1;
                end else begin
                    px     = r_right_x;
                    n_pair = 1'b0;
                    if (r_walk_y < r_bottom_y) begin
                        n_walk_y = r_walk_y + 1'b1;
                    end else begin
                        n_walk_y = r_top_y;
                        n_phase  = 1'b1;
                    end
                end
            end else begin
                if (!r_pair) begin
                    py     = r_top_y;
                    n_pair = 1'b1;
                end else begin
                    py     = r_bottom_y;
                    n_pair = 1'b0;
                    if (r_walk_x < r_right_x) begin
                        n_walk_x = r_walk_x + 1'b1;
                    end else begin
                        last = 1'b1;
                    end
                end
            end
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    // Window words wrap at 16 bits.
    assign o_q_data.xw   = WORD_BITS'(px) + WORD_BITS'(2) - WORD_BITS'(i_orientation[1]);
    assign o_q_data.yw   = WORD_BITS'(py) + WORD_BITS'(1) + WORD_BITS'(i_orientation[1]);
    assign o_q_data.last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_x   <= '0;
            r_right_x  <= '0;
            r_top_y    <= '0;
            r_bottom_y <= '0;
            r_walk_x   <= '0;
            r_walk_y   <= '0;
            r_fill     <= 1'b0;
            r_phase    <= 1'b0;
            r_pair     <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            r_left_x   <= n_left_x;
            r_right_x  <= n_right_x;
            r_top_y    <= n_top_y;
            r_bottom_y <= n_bottom_y;
            r_walk_x   <= n_walk_x;
            r_walk_y   <= n_walk_y;
            r_fill     <= n_fill;
            r_phase    <= n_phase;
            r_pair     <= n_pair;
            r_busy     <= n_busy;
        end
    end

endmodule

// ===== src/rpsf_queue.sv =====
// Short point queue between the front and back ends.
module rpsf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rpsf_pkg::t_point i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rpsf_pkg::t_point o_data
);
    import rpsf_pkg::*;

    t_point              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/rpsf_back.sv =====
// Back end: serialises each queued point into its 13-byte display frame.
module rpsf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  rpsf_pkg::t_point  i_q_data,
    output logic              o_q_pop,
    input  logic [15:0]       i_fore_color,
    input  logic              i_pop,
    output logic              o_empty,
    output rpsf_pkg::t_out_item o_out
);
    import rpsf_pkg::*;

    t_point           r_cur;
    logic             r_cur_valid;
    logic [IDX_W-1:0] r_idx;
    t_out_item        r_out;
    logic             r_out_valid;
    logic             out_free, frame_end, take;
    t_out_item        n_out;

    assign out_free  = !r_out_valid || i_pop;
    assign frame_end = r_cur_valid && out_free && (r_idx == POS_COL_LO);
    assign take      = !i_q_empty && (!r_cur_valid || frame_end);
    assign o_q_pop   = take;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    always_comb begin
        n_out.is_data    = 1'b1;
        n_out.point_last = (r_idx == POS_COL_LO);
        n_out.rect_done  = (r_idx == POS_COL_LO) && r_cur.last;
        case (r_idx) inside
            POS_CMD_COL: begin
                n_out.spi_byte = CMD_COL;
                n_out.is_data  = 1'b0;
            end
            POS_XS_HI, POS_XE_HI: n_out.spi_byte = r_cur.xw[15:8];
            POS_XS_LO, POS_XE_LO: n_out.spi_byte = r_cur.xw[7:0];
            POS_CMD_ROW: begin
                n_out.spi_byte = CMD_ROW;
                n_out.is_data  = 1'b0;
            end
            POS_YS_HI, POS_YE_HI: n_out.spi_byte = r_cur.yw[15:8];
            POS_YS_LO, POS_YE_LO: n_out.spi_byte = r_cur.yw[7:0];
            POS_CMD_MEM: begin
                n_out.spi_byte = CMD_MEM;
                n_out.is_data  = 1'b0;
            end
            POS_COL_HI: n_out.spi_byte = i_fore_color[15:8];
            default:    n_out.spi_byte = i_fore_color[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_cur_valid && out_free) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                r_idx       <= frame_end ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_cur       <= i_q_data;
                r_cur_valid <= 1'b1;
            end else if (frame_end) begin
                r_cur_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/rect_point_spi_framer.sv =====
// Rectangle point framer top level: configuration registers, front end, queue, back end.
// Each step transfer on a loaded rectangle yields one 13-byte window/colour frame; the byte
// serialiser sends one byte per cycle while the output is drained by pop, and push is held off
// by full while the two-point queue is full. Load transfers and steps while idle take one cycle
// and produce nothing. The first byte of a point passes the queue, the back end's current
// point register and its output register. fore_color is register 0, orientation register 1.
module rect_point_spi_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rpsf_pkg::t_in_item  i_in,
    output logic                empty,
    input  logic                pop,
    output rpsf_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import rpsf_pkg::*;

    logic [15:0] r_fore_color;
    logic [1:0]  r_orientation;
    logic        q_push, q_full, q_empty, q_pop;
    t_point      q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore_color  <= '0;
            r_orientation <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FORE_COLOR:  r_fore_color  <= i_cfg_data;
                REG_ORIENTATION: r_orientation <= i_cfg_data[1:0];
            endcase
        end
    end

    rpsf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_in          (i_in),
        .i_orientation (r_orientation),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    rpsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    rpsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .i_fore_color (r_fore_color),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending straight after reset");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.rect_done) |-> o_out.point_last)
        else $error("rect_done without point_last");

    a_cmd_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.is_data) |-> (o_out.spi_byte == CMD_COL ||
            o_out.spi_byte == CMD_ROW || o_out.spi_byte == CMD_MEM))
        else $error("command byte is not a window or memory command");

    a_no_pop_when_empty_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a point from an empty queue");
`endif

endmodule
